// ----- hw/rtl/longest_bitonic_subsequence_length_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the bitonic subsequence length unit
// Concurrent property wrappers shared by the checker.
// ----------------------------------------------------------------------------
`ifndef LONGEST_BITONIC_SUBSEQUENCE_LENGTH_UNIT_DEFINES_SVH
`define LONGEST_BITONIC_SUBSEQUENCE_LENGTH_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define LBSL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define LBSL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/lbsl_pkg.sv -----
// ----------------------------------------------------------------------------
// lbsl_pkg
// Types and constants shared by the bitonic subsequence length unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lbsl_pkg;

  localparam int MAX_ELEMENTS_DEF = 128;
  localparam int VALUE_W          = 31;
  localparam int RESULT_W         = 8;

  // one input transfer
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
  } in_t;

  // one result transfer
  typedef struct packed {
    logic [RESULT_W-1:0] bitonic_length;
    logic                overflow;
  } out_t;

  // per-cycle commands broadcast from the controller to every cell
  typedef struct packed {
    logic shift;
    logic flush;
    logic rise_start;
    logic fall_start;
    logic max_start;
    logic rise_run;
    logic fall_run;
    logic max_run;
  } ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lbsl_cell.sv -----
// ----------------------------------------------------------------------------
// lbsl_cell
// One element of the chain: holds a value and its two run lengths, relays
// length tokens between neighbours and folds the running maximum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbsl_cell #(
  parameter int LW = 8
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire lbsl_pkg::ctl_t          ctl,
  input  wire                          is_head,
  input  wire                          lft_valid,
  input  wire [lbsl_pkg::VALUE_W-1:0]  lft_value,
  input  wire                          rgt_valid,
  input  wire                          ltok_vld,
  input  wire [lbsl_pkg::VALUE_W-1:0]  ltok_val,
  input  wire [LW-1:0]                 ltok_len,
  input  wire                          rtok_vld,
  input  wire [lbsl_pkg::VALUE_W-1:0]  rtok_val,
  input  wire [LW-1:0]                 rtok_len,
  input  wire [LW-1:0]                 rgt_best,
  output logic                         valid_r,
  output logic [lbsl_pkg::VALUE_W-1:0] value_r,
  output logic                         tok_vld_r,
  output logic [lbsl_pkg::VALUE_W-1:0] tok_val_r,
  output logic [LW-1:0]                tok_len_r,
  output logic [LW-1:0]                best_r
);

  logic [LW-1:0]                rise_r;
  logic [LW-1:0]                fall_r;
  logic                         seen_r;
  logic                         sent_r;

  logic                         run;
  logic                         any_start;
  logic                         in_vld;
  logic [lbsl_pkg::VALUE_W-1:0] in_val;
  logic [LW-1:0]                in_len;
  logic [LW-1:0]                len_cur;
  logic                         src;
  logic                         hit;
  logic                         emit;
  logic [LW:0]                  sum;
  logic [LW-1:0]                own;
  logic [LW-1:0]                best_nxt;

  // pick the token stream for the active pass
  always_comb begin
    run       = ctl.rise_run | ctl.fall_run;
    any_start = ctl.rise_start | ctl.fall_start | ctl.max_start;
    in_vld    = ctl.rise_run ? rtok_vld : ltok_vld;
    in_val    = ctl.rise_run ? rtok_val : ltok_val;
    in_len    = ctl.rise_run ? rtok_len : ltok_len;
    len_cur   = ctl.rise_run ? rise_r : fall_r;
    // rising pass starts at the oldest element, falling pass at the newest
    src       = ctl.rise_run ? (valid_r & ~rgt_valid) : is_head;
    hit       = valid_r & in_vld & (in_val < value_r) & (in_len >= len_cur);
    // inject own length into the first gap after the predecessors passed
    emit      = run & ~in_vld & valid_r & ~sent_r & (seen_r | src);
    sum       = {1'b0, rise_r} + {1'b0, fall_r} - (LW + 1)'(1);
    own       = valid_r ? sum[LW-1:0] : '0;
    best_nxt  = (own > rgt_best) ? own : rgt_best;
  end

  // control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      tok_vld_r <= 1'b0;
      seen_r    <= 1'b0;
      sent_r    <= 1'b0;
    end else begin
      if (ctl.flush) begin
        valid_r <= 1'b0;
      end else if (ctl.shift) begin
        valid_r <= lft_valid;
      end
      if (any_start) begin
        tok_vld_r <= 1'b0;
        seen_r    <= 1'b0;
        sent_r    <= 1'b0;
      end else if (run) begin
        tok_vld_r <= in_vld | emit;
        if (in_vld) begin
          seen_r <= 1'b1;
        end
        if (emit) begin
          sent_r <= 1'b1;
        end
      end
    end
  end

  // payload: element, lengths, token and running maximum
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      value_r <= lft_value;
    end
    if (run) begin
      tok_val_r <= in_vld ? in_val : value_r;
      tok_len_r <= in_vld ? in_len : len_cur;
    end
    if (ctl.rise_start) begin
      rise_r <= LW'(1);
    end else if (ctl.rise_run && hit) begin
      rise_r <= in_len + LW'(1);
    end
    if (ctl.fall_start) begin
      fall_r <= LW'(1);
    end else if (ctl.fall_run && hit) begin
      fall_r <= in_len + LW'(1);
    end
    if (ctl.max_start) begin
      best_r <= '0;
    end else if (ctl.max_run) begin
      best_r <= best_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lbsl_ctrl.sv -----
// ----------------------------------------------------------------------------
// lbsl_ctrl
// Sequencer for load and the three chain passes, element count, drop flag
// and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lbsl_ctrl #(
  parameter int MAX_ELEMENTS = lbsl_pkg::MAX_ELEMENTS_DEF,
  parameter int LW           = $clog2(MAX_ELEMENTS + 1)
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  input  wire                 in_last,
  output logic                in_stall,
  output logic                out_valid,
  input  wire                 out_stall,
  output lbsl_pkg::out_t      out_data,
  output lbsl_pkg::ctl_t      ctl,
  input  wire [LW-1:0]        best
);

  localparam int CW = $clog2(MAX_ELEMENTS + 1);

  typedef enum logic [3:0] {
    S_LOAD = 4'b0001,
    S_RISE = 4'b0010,
    S_FALL = 4'b0100,
    S_MAXP = 4'b1000
  } state_t;

  state_t         state_r, state_nxt;
  logic [CW:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           dropped_r, dropped_nxt;
  logic           out_valid_r;
  lbsl_pkg::out_t out_data_r;

  logic [CW:0]    pass_end;
  logic [CW:0]    max_end;
  logic           out_free;
  logic           capture;
  logic [LW+7:0]  best_ext;
  logic [7:0]     len_sat;

  always_comb begin
    pass_end = {count_r, 1'b0} - (CW + 1)'(1);
    max_end  = {1'b0, count_r};
    out_free = ~out_valid_r | ~out_stall;
    best_ext = {8'd0, best};
    len_sat  = (best_ext > (LW + 8)'(255)) ? 8'hFF : best_ext[7:0];
  end

  // sequence the passes
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    count_nxt   = count_r;
    dropped_nxt = dropped_r;
    ctl         = '0;
    capture     = 1'b0;
    in_stall    = 1'b1;
    unique case (state_r)
      S_LOAD: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (count_r < CW'(MAX_ELEMENTS)) begin
            ctl.shift = 1'b1;
            count_nxt = count_r + CW'(1);
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_last) begin
            ctl.rise_start = 1'b1;
            cnt_nxt        = '0;
            state_nxt      = S_RISE;
          end
        end
      end
      S_RISE: begin
        if (cnt_r == pass_end) begin
          ctl.fall_start = 1'b1;
          cnt_nxt        = '0;
          state_nxt      = S_FALL;
        end else begin
          ctl.rise_run = 1'b1;
          cnt_nxt      = cnt_r + (CW + 1)'(1);
        end
      end
      S_FALL: begin
        if (cnt_r == pass_end) begin
          ctl.max_start = 1'b1;
          cnt_nxt       = '0;
          state_nxt     = S_MAXP;
        end else begin
          ctl.fall_run = 1'b1;
          cnt_nxt      = cnt_r + (CW + 1)'(1);
        end
      end
      S_MAXP: begin
        if (cnt_r == max_end) begin
          // hold here until the result register is free
          if (out_free) begin
            capture     = 1'b1;
            ctl.flush   = 1'b1;
            count_nxt   = '0;
            dropped_nxt = 1'b0;
            state_nxt   = S_LOAD;
          end
        end else begin
          ctl.max_run = 1'b1;
          cnt_nxt     = cnt_r + (CW + 1)'(1);
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      count_r     <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      count_r   <= count_nxt;
      dropped_r <= dropped_nxt;
      if (capture) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (capture) begin
      out_data_r.bitonic_length <= len_sat;
      out_data_r.overflow       <= dropped_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- hw/rtl/longest_bitonic_subsequence_length_unit.sv -----
// ----------------------------------------------------------------------------
// longest_bitonic_subsequence_length_unit
// Longest bitonic subsequence length over a loaded sequence, computed in a
// chain of element cells.
// in_*  : one element per transfer; in_data.last closes the sequence.
//         Loading accepts one element per cycle. Elements beyond
//         MAX_ELEMENTS are dropped and reported in out_data.overflow.
// out_* : one result per sequence, held in an output register.
// After the last element the unit runs the rising-length pass, the
//   falling-length pass (tokens move one cell a cycle and each cell
//   injects after its neighbour) and the maximum sweep, then writes the
//   result register. No new sequence loads during these passes.
// in_stall is high from the last element until the result is registered.
// If the receiver stalls, the finished result is held and the next
//   sequence loads; a further result waits in the max sweep until the
//   output register is free.
// Reset (rst_n low, synchronous) empties the chain and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module longest_bitonic_subsequence_length_unit #(
  parameter int MAX_ELEMENTS = lbsl_pkg::MAX_ELEMENTS_DEF
) (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_valid,
  output logic           in_stall,
  input  wire lbsl_pkg::in_t  in_data,
  output logic           out_valid,
  input  wire            out_stall,
  output lbsl_pkg::out_t out_data
);

  localparam int N  = MAX_ELEMENTS;
  localparam int LW = $clog2(MAX_ELEMENTS + 1);
  localparam int VW = lbsl_pkg::VALUE_W;

  lbsl_pkg::ctl_t ctl;

  logic [N-1:0]          valid_w;
  logic [VW-1:0]         value_w   [N];
  logic [N-1:0]          tok_vld_w;
  logic [VW-1:0]         tok_val_w [N];
  logic [LW-1:0]         tok_len_w [N];
  logic [LW-1:0]         best_w    [N];

  lbsl_ctrl #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .LW           (LW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_data.last),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .ctl       (ctl),
    .best      (best_w[0])
  );

  // build the chain: new elements enter at cell 0 and shift upwards
  for (genvar k = 0; k < N; k++) begin : g_cell
    logic          head;
    logic          l_valid;
    logic [VW-1:0] l_value;
    logic          l_tvld;
    logic [VW-1:0] l_tval;
    logic [LW-1:0] l_tlen;
    logic          r_valid;
    logic          r_tvld;
    logic [VW-1:0] r_tval;
    logic [LW-1:0] r_tlen;
    logic [LW-1:0] r_best;

    if (k == 0) begin : g_first
      assign head    = 1'b1;
      assign l_valid = 1'b1;
      assign l_value = in_data.value;
      assign l_tvld  = 1'b0;
      assign l_tval  = '0;
      assign l_tlen  = '0;
    end else begin : g_mid_l
      assign head    = 1'b0;
      assign l_valid = valid_w[k-1];
      assign l_value = value_w[k-1];
      assign l_tvld  = tok_vld_w[k-1];
      assign l_tval  = tok_val_w[k-1];
      assign l_tlen  = tok_len_w[k-1];
    end

    if (k == N - 1) begin : g_last
      assign r_valid = 1'b0;
      assign r_tvld  = 1'b0;
      assign r_tval  = '0;
      assign r_tlen  = '0;
      assign r_best  = '0;
    end else begin : g_mid_r
      assign r_valid = valid_w[k+1];
      assign r_tvld  = tok_vld_w[k+1];
      assign r_tval  = tok_val_w[k+1];
      assign r_tlen  = tok_len_w[k+1];
      assign r_best  = best_w[k+1];
    end

    lbsl_cell #(
      .LW (LW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .is_head   (head),
      .lft_valid (l_valid),
      .lft_value (l_value),
      .rgt_valid (r_valid),
      .ltok_vld  (l_tvld),
      .ltok_val  (l_tval),
      .ltok_len  (l_tlen),
      .rtok_vld  (r_tvld),
      .rtok_val  (r_tval),
      .rtok_len  (r_tlen),
      .rgt_best  (r_best),
      .valid_r   (valid_w[k]),
      .value_r   (value_w[k]),
      .tok_vld_r (tok_vld_w[k]),
      .tok_val_r (tok_val_w[k]),
      .tok_len_r (tok_len_w[k]),
      .best_r    (best_w[k])
    );
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lbsl_checker.sv -----
// ----------------------------------------------------------------------------
// lbsl_checker
// Port-level checks for the bitonic subsequence length unit, bound to the
// top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "longest_bitonic_subsequence_length_unit_defines.svh"

module lbsl_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_valid,
  input wire                 in_stall,
  input wire lbsl_pkg::in_t  in_data,
  input wire                 out_valid,
  input wire                 out_stall,
  input wire lbsl_pkg::out_t out_data
);

  // a stalled result stays offered
  `LBSL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result dropped under stall")

  // the closing transfer starts the passes, so input stalls next
  `LBSL_ASSERT_NEXT(a_last_stalls, clk, rst_n, in_valid && !in_stall && in_data.last, in_stall, "input not stalled after last transfer")

  // a new result only appears at the end of a compute phase
  `LBSL_ASSERT_SAME(a_rise_after_compute, clk, rst_n, $rose(out_valid), $past(in_stall), "result without compute phase")

  // every sequence holds at least one element
  `LBSL_ASSERT_SAME(a_len_nonzero, clk, rst_n, out_valid, out_data.bitonic_length != 8'd0, "zero length result")

endmodule

bind longest_bitonic_subsequence_length_unit lbsl_checker u_lbsl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// ----- test/tb_longest_bitonic_subsequence_length_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_longest_bitonic_subsequence_length_unit
// Loads sequences into the bitonic length unit and checks each result
// against a behavioural predictor kept in the bench. Directed sequences
// cover single elements, pure rises and falls, repeated values and value
// extremes; a fill test exercises the store limit and dropped elements;
// random sequences of mixed shapes follow. Both handshake sides idle at
// random.
// ----------------------------------------------------------------------------
module tb_longest_bitonic_subsequence_length_unit;

  typedef logic [lbsl_pkg::VALUE_W-1:0] value_t;

  localparam int     DEPTH        = lbsl_pkg::MAX_ELEMENTS_DEF;
  localparam int     RANDOM_ITEMS = 1600;
  localparam int     DRAIN_CYCLES = 5 * DEPTH + 60;
  localparam int     CYCLE_LIMIT  = 1000000;
  localparam value_t VALUE_TOP    = {lbsl_pkg::VALUE_W{1'b1}};

  typedef enum int {SHAPE_WIDE, SHAPE_NARROW, SHAPE_PEAK, SHAPE_EXTREME} shape_t;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_stall;
  lbsl_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_stall;
  lbsl_pkg::out_t out_data;

  // bench-side copy of the unit's state
  value_t         stored_values [$];
  logic           dropped_seen;
  lbsl_pkg::out_t pending_results [$];

  value_t         pattern [$];
  logic           sender_paced;
  int             stall_left;
  int             mismatch_count;
  int             cycle_count;

  longest_bitonic_subsequence_length_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Longest strictly rising run into each position plus longest strictly
  // falling run out of it, best sum over positions
  function automatic logic [lbsl_pkg::RESULT_W-1:0] longest_bitonic_length();
    int rise [0:DEPTH-1];
    int fall [0:DEPTH-1];
    int n;
    int best;
    n    = stored_values.size();
    best = 1;
    for (int j = 0; j < n; j++) begin
      rise[j] = 1;
      fall[j] = 1;
    end
    for (int j = 1; j < n; j++) begin
      for (int i = 0; i < j; i++) begin
        if (stored_values[i] < stored_values[j] && rise[i] + 1 > rise[j]) rise[j] = rise[i] + 1;
      end
    end
    for (int j = n - 2; j >= 0; j--) begin
      for (int i = j + 1; i < n; i++) begin
        if (stored_values[i] < stored_values[j] && fall[i] + 1 > fall[j]) fall[j] = fall[i] + 1;
      end
    end
    for (int j = 0; j < n; j++) begin
      if (rise[j] + fall[j] - 1 > best) best = rise[j] + fall[j] - 1;
    end
    if (best > 255) best = 255;
    return best[lbsl_pkg::RESULT_W-1:0];
  endfunction

  // Send one element; called just after a falling edge, returns just after one
  task automatic transfer_element(input value_t v, input logic l);
    int             gap;
    lbsl_pkg::out_t want;
    gap = sender_paced ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_data.value <= v;
    in_data.last  <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // transfer taken: advance the predicted state
    if (stored_values.size() < DEPTH) stored_values.push_back(v);
    else dropped_seen = 1'b1;
    if (l) begin
      want.bitonic_length = longest_bitonic_length();
      want.overflow       = dropped_seen;
      pending_results.push_back(want);
      stored_values.delete();
      dropped_seen = 1'b0;
    end
    @(negedge clk);
  endtask

  // Send the prepared pattern as one sequence, last flag on the final element
  task automatic send_pattern();
    for (int k = 0; k < pattern.size(); k++) begin
      transfer_element(pattern[k], k == pattern.size() - 1);
    end
    pattern.delete();
  endtask

  task automatic run_directed_sequences();
    sender_paced = 1'b1;
    // single elements at both ends of the range
    pattern.push_back('0);
    send_pattern();
    pattern.push_back(VALUE_TOP);
    send_pattern();
    // pure rise, then pure fall
    for (int k = 1; k <= 4; k++) pattern.push_back(value_t'(k));
    send_pattern();
    pattern.push_back(value_t'(9));
    pattern.push_back(value_t'(5));
    pattern.push_back(value_t'(3));
    pattern.push_back(value_t'(0));
    send_pattern();
    // mixed sequence with a bitonic core
    pattern.push_back(value_t'(1));
    pattern.push_back(value_t'(11));
    pattern.push_back(value_t'(2));
    pattern.push_back(value_t'(10));
    pattern.push_back(value_t'(4));
    pattern.push_back(value_t'(5));
    pattern.push_back(value_t'(2));
    pattern.push_back(value_t'(1));
    send_pattern();
    // equal values never count as rising or falling
    repeat (3) pattern.push_back(value_t'(7));
    send_pattern();
    // extremes side by side
    pattern.push_back(VALUE_TOP);
    pattern.push_back('0);
    send_pattern();
  endtask

  task automatic run_store_limit();
    sender_paced = 1'b0;
    // exactly full: nothing dropped
    for (int k = 0; k < DEPTH; k++) pattern.push_back(value_t'($urandom_range(0, 300)));
    send_pattern();
    // full, then the closing element itself is dropped
    sender_paced = 1'b1;
    for (int k = 0; k < DEPTH + 1; k++) pattern.push_back(value_t'($urandom()));
    send_pattern();
    // several dropped before the close
    sender_paced = 1'b0;
    for (int k = 0; k < DEPTH + 5; k++) begin
      pattern.push_back(value_t'(k < 64 ? k : 2 * DEPTH - k));
    end
    send_pattern();
  endtask

  task automatic run_random_sequences();
    int     sent;
    int     len;
    int     peak;
    int     base;
    shape_t shape;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      len          = ($urandom_range(0, 39) == 0) ? $urandom_range(DEPTH - 8, DEPTH + 12)
                                                  : $urandom_range(1, 24);
      shape        = shape_t'($urandom_range(0, 3));
      sender_paced = $urandom_range(0, 2) != 0;
      peak         = $urandom_range(0, len - 1);
      base         = $urandom_range(1000, 1000000);
      for (int k = 0; k < len; k++) begin
        case (shape)
          SHAPE_WIDE: begin
            pattern.push_back(value_t'($urandom()));
          end
          SHAPE_NARROW: begin
            pattern.push_back(value_t'($urandom_range(0, 7)));
          end
          SHAPE_PEAK: begin
            pattern.push_back(value_t'(base + 4 * (k <= peak ? k : 2 * peak - k)
                                       + $urandom_range(0, 5)));
          end
          default: begin
            pattern.push_back($urandom_range(0, 1) ? VALUE_TOP : '0);
          end
        endcase
      end
      send_pattern();
      sent += len;
    end
  endtask

  // Receiver pacing: hold stall for the drawn count of cycles with a result up
  always @(negedge clk) begin
    out_stall <= stall_left > 0;
    if (stall_left > 0 && out_valid) stall_left <= stall_left - 1;
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin : check_results
    lbsl_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, length %0d overflow %0b", $time,
                 out_data.bitonic_length, out_data.overflow);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.bitonic_length !== want.bitonic_length) begin
          $display("%0t: bitonic_length expected %0d, actual %0d", $time,
                   want.bitonic_length, out_data.bitonic_length);
          mismatch_count++;
        end
        if (out_data.overflow !== want.overflow) begin
          $display("%0t: overflow expected %0b, actual %0b", $time,
                   want.overflow, out_data.overflow);
          mismatch_count++;
        end
      end
      stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
    end
  end

  // Guard against a hung handshake
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_stall      = 1'b0;
    stall_left     = 0;
    dropped_seen   = 1'b0;
    sender_paced   = 1'b0;
    mismatch_count = 0;
    cycle_count    = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_directed_sequences();
    run_store_limit();
    run_random_sequences();
    in_valid <= 1'b0;

    // drain outstanding results, then watch for strays
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
